// ===== hw/rtl/edge_interrupt_line_controller_macros.svh =====
// Assertion macros shared by the edge interrupt line controller RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef EDGE_INTERRUPT_LINE_CONTROLLER_MACROS_SVH
`define EDGE_INTERRUPT_LINE_CONTROLLER_MACROS_SVH

// Antecedent holds in this cycle implies consequent in the same cycle.
`define EILC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds in this cycle implies consequent in the next cycle.
`define EILC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/eilc_pkg.sv =====
// Shared constants and types of the edge interrupt line controller.
// No dependencies; imported by eilc_cell and edge_interrupt_line_controller.
package eilc_pkg;

  localparam int LineCount  = 16;  // lines actually built, 1 to 16
  localparam int PortCount  = 6;   // ports a select may address, 1 to 16
  localparam int InputPorts = 6;   // ports present on the interface
  localparam int NumLines   = 16;  // width of every per-line vector
  localparam int LevelW     = 16;  // width of one port's pin word
  localparam int SelW       = 4;
  localparam int LineIdxW   = 4;
  localparam int PortIdxW   = $clog2(InputPorts);
  localparam int SelLimit   = (PortCount < InputPorts) ? PortCount : InputPorts;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegRisingEnable  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFallingEnable = 2'd1;
  localparam logic [CfgIdxW-1:0] RegInterruptMask = 2'd2;
  localparam logic [CfgIdxW-1:0] RegPortSelect    = 2'd3;

  localparam logic KindSample = 1'b0;
  localparam logic KindClear  = 1'b1;

  localparam int IrqW = 7;
  localparam logic [NumLines-1:0] GroupMidMask  = 16'h03E0;
  localparam logic [NumLines-1:0] GroupHighMask = 16'hFC00;

  // Priority hand-off between neighbouring cells.
  typedef struct packed {
    logic                found;
    logic [LineIdxW-1:0] line;
  } eilc_serve_t;

  // One result word.
  typedef struct packed {
    logic [NumLines-1:0] pending;
    logic [IrqW-1:0]     irq;
    logic                serve_valid;
    logic [LineIdxW-1:0] serve_line;
  } eilc_result_t;

endpackage

// ===== hw/rtl/eilc_cell.sv =====
// One interrupt line: pin selection, edge detection and the pending flag.
// Depends on eilc_pkg; chained by edge_interrupt_line_controller.
module eilc_cell import eilc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  kind_i,
  input  logic [InputPorts-1:0] pins_i,
  input  logic [SelW-1:0]       sel_i,
  input  logic                  rise_en_i,
  input  logic                  fall_en_i,
  input  logic                  mask_i,
  input  logic                  clear_i,
  input  logic [LineIdxW-1:0]   line_idx_i,
  input  eilc_serve_t           serve_i,
  output eilc_serve_t           serve_o,
  output logic                  pend_d_o,
  output logic                  pend_q_o
);

  logic prev_q, prev_d;
  logic pend_q, pend_d;
  logic level;
  logic active;

  // A select beyond the ports present reads as a low pin.
  assign level = (sel_i < SelW'(SelLimit)) ? pins_i[sel_i[PortIdxW-1:0]] : 1'b0;

  always_comb begin
    prev_d = prev_q;
    pend_d = pend_q;
    if (step_i) begin
      if (kind_i == KindSample) begin
        pend_d = pend_q | (level & ~prev_q & rise_en_i) | (~level & prev_q & fall_en_i);
        prev_d = level;
      end else begin
        pend_d = pend_q & ~clear_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      prev_q <= prev_d;
      pend_q <= pend_d;
    end
  end

  // Higher lines override what lower neighbours found.
  assign active        = pend_d & mask_i;
  assign serve_o.found = serve_i.found | active;
  assign serve_o.line  = active ? line_idx_i : serve_i.line;
  assign pend_d_o      = pend_d;
  assign pend_q_o      = pend_q;

endmodule

// ===== hw/rtl/edge_interrupt_line_controller.sv =====
// Top level of the edge interrupt line controller.
// Depends on eilc_pkg, eilc_cell and edge_interrupt_line_controller_macros.svh.
//
// Sixteen external interrupt lines, each fed by one pin chosen from six
// ports by a four-bit select; select values of six and above read as a low
// pin. A sample word (kind 0) compares each selected pin with its stored
// previous level and raises the line's pending flag on an enabled rising
// or falling edge, whatever the mask says. A clear word (kind 1) clears the
// pending flags where clear_bits holds a one and leaves the stored levels
// alone. Every input word yields exactly one result word: the pending
// flags after the update, seven grouped interrupt request lines (lines 0
// to 4 singly, then any of lines 5 to 9, then any of lines 10 to 15), and
// the highest pending unmasked line, or 0 with serve_valid low if none.
// The block takes one word per clock cycle while in_ready_o is high. Each
// line is a cell holding its previous level and pending flag; the cells
// are chained from line 0 upward so that each hands the highest active
// line found so far to its neighbour. Results are registered in an output
// register backed by a one-word skid stage, so a stalled output still lets
// one more word in. Configuration registers (rising enable, falling enable,
// mask, port select at indices 0 to 3) are written through cfg_we_i and
// take effect at once; write them only while the block is idle.
module edge_interrupt_line_controller import eilc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic [LevelW-1:0]   port_a_levels_i,
  input  logic [LevelW-1:0]   port_b_levels_i,
  input  logic [LevelW-1:0]   port_c_levels_i,
  input  logic [LevelW-1:0]   port_d_levels_i,
  input  logic [LevelW-1:0]   port_e_levels_i,
  input  logic [LevelW-1:0]   port_f_levels_i,
  input  logic [NumLines-1:0] clear_bits_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [NumLines-1:0] pending_bits_o,
  output logic [IrqW-1:0]     irq_lines_o,
  output logic                serve_valid_o,
  output logic [LineIdxW-1:0] serve_line_o
);

`include "edge_interrupt_line_controller_macros.svh"

  // Configuration registers.
  logic [NumLines-1:0]      rise_en_q, fall_en_q, mask_q;
  logic [NumLines*SelW-1:0] sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_en_q <= '0;
      fall_en_q <= '0;
      mask_q    <= '0;
      sel_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegRisingEnable:  rise_en_q <= cfg_wdata_i[NumLines-1:0];
        RegFallingEnable: fall_en_q <= cfg_wdata_i[NumLines-1:0];
        RegInterruptMask: mask_q    <= cfg_wdata_i[NumLines-1:0];
        RegPortSelect:    sel_q     <= cfg_wdata_i[NumLines*SelW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake. The skid stage only fills when the output register is held.
  logic         push, pop;
  logic         out_valid_q, skid_valid_q;
  eilc_result_t out_q, skid_q, result;

  assign in_ready_o = !skid_valid_q;
  assign push       = in_valid_i && in_ready_o;
  assign pop        = out_valid_q && out_ready_i;

  // Port words gathered so that each cell can pick its own bit.
  logic [InputPorts-1:0][LevelW-1:0] port_lvl;
  assign port_lvl[0] = port_a_levels_i;
  assign port_lvl[1] = port_b_levels_i;
  assign port_lvl[2] = port_c_levels_i;
  assign port_lvl[3] = port_d_levels_i;
  assign port_lvl[4] = port_e_levels_i;
  assign port_lvl[5] = port_f_levels_i;

  eilc_serve_t         chain [LineCount+1];
  logic [NumLines-1:0] pend_d_vec, pend_q_vec, active;

  assign chain[0] = '0;

  for (genvar g = 0; g < NumLines; g++) begin : g_line
    if (g < LineCount) begin : g_built
      logic [InputPorts-1:0] pins;
      for (genvar p = 0; p < InputPorts; p++) begin : g_pin
        assign pins[p] = port_lvl[p][g];
      end
      eilc_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .step_i     (push),
        .kind_i     (kind_i),
        .pins_i     (pins),
        .sel_i      (sel_q[g*SelW +: SelW]),
        .rise_en_i  (rise_en_q[g]),
        .fall_en_i  (fall_en_q[g]),
        .mask_i     (mask_q[g]),
        .clear_i    (clear_bits_i[g]),
        .line_idx_i (LineIdxW'(g)),
        .serve_i    (chain[g]),
        .serve_o    (chain[g+1]),
        .pend_d_o   (pend_d_vec[g]),
        .pend_q_o   (pend_q_vec[g])
      );
    end else begin : g_absent
      // Lines that are not built never become pending.
      assign pend_d_vec[g] = 1'b0;
      assign pend_q_vec[g] = 1'b0;
    end
  end

  assign active = pend_d_vec & mask_q;

  always_comb begin
    result.pending     = pend_d_vec;
    result.irq         = {|(active & GroupHighMask), |(active & GroupMidMask), active[4:0]};
    result.serve_valid = chain[LineCount].found;
    result.serve_line  = chain[LineCount].line;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || pop) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= push;
        end
      end else if (push) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= result;
      end
    end else if (push) begin
      skid_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pending_bits_o = out_q.pending;
  assign irq_lines_o    = out_q.irq;
  assign serve_valid_o  = out_q.serve_valid;
  assign serve_line_o   = out_q.serve_line;

  `EILC_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q,
    "skid stage holds a word while the output register is empty")
  `EILC_ASSERT_IMP(a_serve_matches_irq, out_valid_o, serve_valid_o == (irq_lines_o != '0),
    "serve_valid disagrees with the grouped request lines")
  `EILC_ASSERT_IMP(a_no_serve_line_zero, out_valid_o && !serve_valid_o, serve_line_o == '0,
    "serve_line is not zero although nothing is served")
  `EILC_ASSERT_NEXT(a_clear_takes_effect, push && kind_i == KindClear,
    (pend_q_vec & $past(clear_bits_i)) == '0,
    "a cleared pending flag is still set after the clear word")

endmodule
